### rtl/bitmap_block_allocator_defines.svh
// Assertion macros used by the checker file of the allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap_block_allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap_block_allocator check failed");

`endif

### rtl/bba_pkg.sv
`timescale 1ns / 1ps
package bba_pkg;

   localparam int REG_W          = 11;
   localparam int IDX_W          = 10;
   localparam int CSR_IDX_W      = 1;
   localparam int DEF_MAX_BLOCKS = 1024;
   localparam int DEF_WORD_BITS  = 32;

   localparam logic [CSR_IDX_W-1:0] REG_RESERVED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL    = 1'b1;

   localparam logic [REG_W-1:0] RESET_RESERVED = 11'd1;
   localparam logic [REG_W-1:0] RESET_TOTAL    = 11'd1024;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_ALLOC = 2'd2;
   localparam logic [1:0] STAT_RANGE     = 2'd3;

   typedef struct packed {
      logic [1:0]       func;
      logic [IDX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] result_index;
      logic             is_used;
      logic [1:0]       status;
   } rsp_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL
   } state_type;

   typedef struct packed {
      logic accept;
      logic eval;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic done;
   } sts_type;

endpackage

### rtl/bba_ram.sv
`timescale 1ns / 1ps
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/bba_ctrl.sv
`timescale 1ns / 1ps
module bba_ctrl import bba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (sts.done) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd.accept = (state_ff == S_IDLE) && start;
      cmd.eval   = (state_ff == S_EVAL);
      cmd.clear  = (state_ff == S_CLEAR);
      busy       = (state_ff != S_IDLE);
   end

endmodule

### rtl/bba_dpath.sv
`timescale 1ns / 1ps
module bba_dpath import bba_pkg::*; #(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int WORD_BITS  = DEF_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  req_type              req_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   output rsp_type              rsp_data
);

   localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int BLK_W     = ADDR_W + BIT_W;
   localparam int BND_W     = $clog2(MAX_BLOCKS + 1);
   localparam int W1        = (BND_W > REG_W) ? BND_W : REG_W;
   localparam int CMP_W     = ((W1 > BLK_W) ? W1 : BLK_W) + 1;

   logic [REG_W-1:0]     reserved_ff, reserved_in;
   logic [REG_W-1:0]     total_ff, total_in;
   logic [1:0]           func_ff, func_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [ADDR_W-1:0]    word_ff, word_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [CMP_W-1:0]     res_c, tot_c, bound_c, idx_c, base_c, next_base_c, alloc_blk;
   logic [CMP_W-1:0]     res_word_c, req_word_c;
   logic [WORD_BITS-1:0] rd_data, free_vec, alloc_word, free_word;
   logic [BIT_W-1:0]     pos;
   logic                 found, empty_range, in_range, cur_bit;
   logic                 done_c, eval_we;
   logic [WORD_BITS-1:0] eval_wdata;
   rsp_type              eval_rsp;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;

   bba_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (word_in),
      .rdata (rd_data)
   );

   // Bounds of the usable block space, compared at a common width.
   always_comb begin
      res_c       = CMP_W'(reserved_ff);
      tot_c       = CMP_W'(total_ff);
      bound_c     = (tot_c > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : tot_c;
      idx_c       = CMP_W'(idx_ff);
      base_c      = CMP_W'({word_ff, {BIT_W{1'b0}}});
      next_base_c = base_c + CMP_W'(WORD_BITS);
      empty_range = (res_c >= bound_c);
      in_range    = (idx_c >= res_c) && (idx_c < bound_c);
      cur_bit     = rd_data[idx_ff[BIT_W-1:0]];
      res_word_c  = CMP_W'(reserved_ff) >> BIT_W;
      req_word_c  = CMP_W'(req_data.block_index) >> BIT_W;
   end

   // Lowest free bit of the current word that lies inside the block space.
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         free_vec[b] = !rd_data[b] && (base_c + CMP_W'(b) >= res_c)
                       && (base_c + CMP_W'(b) < bound_c);
      end
      found = 1'b0;
      pos   = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_vec[b]) begin
            found = 1'b1;
            pos   = BIT_W'(b);
         end
      end
      alloc_blk  = base_c + CMP_W'(pos);
      alloc_word = rd_data | (WORD_BITS'(1) << pos);
      free_word  = rd_data & ~(WORD_BITS'(1) << idx_ff[BIT_W-1:0]);
   end

   always_comb begin
      done_c                = 1'b1;
      eval_we               = 1'b0;
      eval_wdata            = rd_data;
      eval_rsp.result_index = idx_ff;
      eval_rsp.is_used      = 1'b0;
      eval_rsp.status       = STAT_OK;
      unique case (func_ff)
         FUNC_ALLOC: begin
            eval_rsp.result_index = '0;
            eval_rsp.status       = STAT_FULL;
            if (!empty_range && found) begin
               eval_we               = 1'b1;
               eval_wdata            = alloc_word;
               eval_rsp.result_index = alloc_blk[IDX_W-1:0];
               eval_rsp.status       = STAT_OK;
            end else if (!empty_range && (next_base_c < bound_c)) begin
               done_c = 1'b0;
            end
         end
         FUNC_FREE: begin
            if (!in_range) begin
               eval_rsp.status = STAT_RANGE;
            end else if (!cur_bit) begin
               eval_rsp.status = STAT_NOT_ALLOC;
            end else begin
               eval_we    = 1'b1;
               eval_wdata = free_word;
            end
         end
         FUNC_QUERY: begin
            if (!in_range) begin
               eval_rsp.status = STAT_RANGE;
            end else begin
               eval_rsp.is_used = cur_bit;
            end
         end
         default: begin
            eval_rsp.status = STAT_RANGE;
         end
      endcase
   end

   // The read address is the next word register, so the registered read data
   // always belongs to the word held in word_ff.
   always_comb begin
      func_in = func_ff;
      idx_in  = idx_ff;
      word_in = word_ff;
      if (cmd.accept) begin
         func_in = req_data.func;
         idx_in  = req_data.block_index;
         word_in = (req_data.func == FUNC_ALLOC) ? res_word_c[ADDR_W-1:0]
                                                 : req_word_c[ADDR_W-1:0];
      end else if (cmd.eval && !done_c) begin
         word_in = word_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      if (cmd.clear) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = cmd.eval && eval_we;
         ram_waddr = word_ff;
         ram_wdata = eval_wdata;
      end
      clr_in         = cmd.clear ? clr_ff + ADDR_W'(1) : clr_ff;
      sts.clear_last = (clr_ff == ADDR_W'(NUM_WORDS - 1));
      sts.done       = done_c;
      rsp_valid_in   = cmd.eval && done_c;
      rsp_data_in    = rsp_valid_in ? eval_rsp : rsp_data_ff;
   end

   always_comb begin
      reserved_in = reserved_ff;
      total_in    = total_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_RESERVED: reserved_in = csr_wdata;
            REG_TOTAL:    total_in    = csr_wdata;
            default:      reserved_in = reserved_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff  <= RESET_RESERVED;
         total_ff     <= RESET_TOTAL;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         reserved_ff  <= reserved_in;
         total_ff     <= total_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      idx_ff      <= idx_in;
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// First-fit block allocator over a bitmap kept in a word-wide RAM.
// Requests enter on req_data (func, block_index) and are taken at a clock
// edge where start is high and busy is low. Each request gives one result
// on rsp_data, shown for exactly one cycle with rsp_valid high; the receiver
// cannot stall it, so it must take the result in that cycle.
// Free and query read one bitmap word: it is registered at the RAM output,
// evaluated, and its result is registered onto rsp_data. Allocate scans
// one word per cycle from the word holding reserved_blocks upward until it
// finds a free block or passes the end of the block space; the scan runs
// over the single RAM read port. A new request may be accepted in the
// cycle its predecessor's result is shown.
// The csr_ port writes reserved_blocks (index 0) and total_blocks (index 1)
// at any edge where csr_we is high; write them only while the block is idle.
// After reset a clearing pass writes zeros to every bitmap word, one word a
// cycle, with busy high; registers return to reserved_blocks 1 and
// total_blocks 1024.
module bitmap_block_allocator import bba_pkg::*; #(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int WORD_BITS  = DEF_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_type              req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   bba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   bba_dpath #(.MAX_BLOCKS(MAX_BLOCKS), .WORD_BITS(WORD_BITS)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/bba_checker.sv
`timescale 1ns / 1ps
`include "bitmap_block_allocator_defines.svh"
module bba_checker import bba_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // An accepted item keeps the block busy for at least the next cycle.
   `BBA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A result only follows a cycle in which an item was being worked on.
   `BBA_ASSERT_SAME(a_rsp_after_work, clock, reset, rsp_valid, $past(busy))
   // Results of consecutive items never come in adjacent cycles.
   `BBA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // Only a successful query can report a used block.
   `BBA_ASSERT_SAME(a_used_ok, clock, reset, rsp_valid && rsp_data.is_used,
                    rsp_data.status == STAT_OK)
   // A full map hands out no block.
   `BBA_ASSERT_SAME(a_full_zero, clock, reset,
                    rsp_valid && (rsp_data.status == STAT_FULL),
                    rsp_data.result_index == '0)

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### tb/bitmap_block_allocator_test.sv
`timescale 1ns / 1ps
module bitmap_block_allocator_test;
   import bba_pkg::*;

   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 40;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 75;

   typedef enum logic [1:0] {
      ENTRY_REQ,
      ENTRY_CSR,
      ENTRY_DRAIN
   } entry_kind_type;

   typedef struct {
      entry_kind_type         kind;
      req_type                req;
      logic [CSR_IDX_W-1:0]   csr_sel;
      logic [REG_W-1:0]       wdata;
      int                     gap;
   } pending_entry_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   req_type              req_data = '0;
   logic                 busy;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]     csr_wdata = '0;

   // Predictor state: one bit per block plus the two registers.
   bit                   usage_map [DEF_MAX_BLOCKS];
   logic [REG_W-1:0]     reserved_model;
   logic [REG_W-1:0]     total_model;

   pending_entry_type    pending_work [$];
   pending_entry_type    head;
   rsp_type              expected_rsp [$];
   int                   total_requests = 0;
   int                   accepted_count = 0;
   int                   failures = 0;
   int                   idle_left = 0;
   int                   quiet_cycles = 0;
   int                   cycle_count = 0;
   logic                 start_next;
   logic                 we_next;

   bitmap_block_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic rsp_type compute_response(req_type item);
      rsp_type res;
      int      bound;
      int      idx;
      int      k;
      bound = (total_model > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(total_model);
      idx = item.block_index;
      res.result_index = item.block_index;
      res.is_used = 1'b0;
      res.status = STAT_OK;
      case (item.func)
         FUNC_ALLOC: begin
            res.result_index = '0;
            res.status = STAT_FULL;
            for (k = reserved_model; k < bound; k++) begin
               if (!usage_map[k]) begin
                  usage_map[k] = 1'b1;
                  res.result_index = k[IDX_W-1:0];
                  res.status = STAT_OK;
                  break;
               end
            end
         end
         FUNC_FREE, FUNC_QUERY: begin
            if (idx < reserved_model || idx >= bound) begin
               res.status = STAT_RANGE;
            end else if (item.func == FUNC_QUERY) begin
               res.is_used = usage_map[idx];
            end else if (!usage_map[idx]) begin
               res.status = STAT_NOT_ALLOC;
            end else begin
               usage_map[idx] = 1'b0;
            end
         end
         default: begin
            res.status = STAT_RANGE;
         end
      endcase
      return res;
   endfunction

   function automatic void push_request(logic [1:0] func, int idx, int gap);
      pending_entry_type e;
      e.kind = ENTRY_REQ;
      e.req.func = func;
      e.req.block_index = idx[IDX_W-1:0];
      e.csr_sel = '0;
      e.wdata = '0;
      e.gap = gap;
      pending_work.push_back(e);
      total_requests++;
   endfunction

   function automatic void push_csr(logic [CSR_IDX_W-1:0] sel, int value);
      pending_entry_type e;
      e.kind = ENTRY_CSR;
      e.req = '0;
      e.csr_sel = sel;
      e.wdata = value[REG_W-1:0];
      e.gap = 0;
      pending_work.push_back(e);
   endfunction

   function automatic void push_drain();
      pending_entry_type e;
      e.kind = ENTRY_DRAIN;
      e.req = '0;
      e.csr_sel = '0;
      e.wdata = '0;
      e.gap = 0;
      pending_work.push_back(e);
   endfunction

   // Mostly indexes near the low end of the space, where allocations land,
   // with some at the space edges and some anywhere.
   function automatic int pick_index(int lo, int hi);
      int sel;
      sel = $urandom_range(0, 9);
      if (lo >= hi || sel == 0) begin
         return $urandom_range(0, 1023);
      end
      if (sel == 1) begin
         return ($urandom_range(0, 1) ? hi : lo - 1) & 10'h3FF;
      end
      if (sel < 8) begin
         return lo + $urandom_range(0, (hi - lo > 48) ? 47 : hi - lo - 1);
      end
      return $urandom_range(lo, hi - 1);
   endfunction

   // Driver: holds start until the item is taken, then works through the queue.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
         idle_left = 0;
         quiet_cycles = 0;
         usage_map = '{default: 1'b0};
         reserved_model = RESET_RESERVED;
         total_model = RESET_TOTAL;
      end else begin
         if (start && !busy) begin
            expected_rsp.push_back(compute_response(req_data));
            accepted_count++;
         end
         if (expected_rsp.size() == 0 && !busy && !start) begin
            quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end
         if (!(start && busy)) begin
            start_next = 1'b0;
            we_next = 1'b0;
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_work.size() > 0) begin
               head = pending_work[0];
               case (head.kind)
                  ENTRY_REQ: begin
                     req_data <= head.req;
                     start_next = 1'b1;
                     idle_left = head.gap;
                     void'(pending_work.pop_front());
                  end
                  ENTRY_CSR: begin
                     if (quiet_cycles >= SETTLE_CYCLES) begin
                        csr_index <= head.csr_sel;
                        csr_wdata <= head.wdata;
                        we_next = 1'b1;
                        if (head.csr_sel == REG_RESERVED) begin
                           reserved_model = head.wdata;
                        end else begin
                           total_model = head.wdata;
                        end
                        void'(pending_work.pop_front());
                     end
                  end
                  default: begin
                     if (quiet_cycles >= SETTLE_CYCLES) begin
                        void'(pending_work.pop_front());
                     end
                  end
               endcase
            end
            start <= start_next;
            csr_we <= we_next;
         end
      end
   end

   // Monitor: every strobed result is matched against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("result with no pending item: index %0d status %0d",
                   rsp_data.result_index, rsp_data.status);
            failures++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.result_index !== want.result_index) begin
               $error("result_index: expected %0d, got %0d",
                      want.result_index, rsp_data.result_index);
               failures++;
            end
            if (rsp_data.is_used !== want.is_used) begin
               $error("is_used: expected %0d, got %0d", want.is_used, rsp_data.is_used);
               failures++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int p;
      int n;
      int r;
      int t;
      int lo;
      int hi;
      int sel;
      int gap;
      bit burst;
      logic [1:0] func;

      // Directed part at the reset settings: reserved 1, total 1024.
      push_request(FUNC_QUERY, 0, 0);
      push_request(FUNC_QUERY, 1, 1);
      push_request(FUNC_FREE, 1, 0);
      push_request(FUNC_ALLOC, 0, 0);
      push_request(FUNC_ALLOC, 1023, 1);
      push_request(FUNC_QUERY, 1, 0);
      push_request(FUNC_FREE, 1, 0);
      push_request(FUNC_ALLOC, 0, 2);
      push_request(FUNC_QUERY, 1023, 0);
      push_request(FUNC_FREE, 1023, 0);
      push_request(FUNC_UNKNOWN, 1023, 1);
      push_request(FUNC_UNKNOWN, 0, 0);
      push_request(FUNC_FREE, 2, 0);
      push_request(FUNC_FREE, 1, 0);
      // A three-block space: fill it, overflow it, then reuse a freed block.
      push_csr(REG_RESERVED, 5);
      push_csr(REG_TOTAL, 8);
      repeat (4) push_request(FUNC_ALLOC, 0, 0);
      push_request(FUNC_QUERY, 8, 1);
      push_request(FUNC_QUERY, 4, 0);
      push_request(FUNC_FREE, 6, 0);
      push_request(FUNC_ALLOC, 0, 0);
      // Reserved count equal to the total leaves no usable block.
      push_csr(REG_RESERVED, 10);
      push_csr(REG_TOTAL, 10);
      push_request(FUNC_ALLOC, 0, 0);
      push_request(FUNC_QUERY, 10, 0);
      push_request(FUNC_FREE, 9, 1);
      // A total beyond the capacity is cut to the capacity.
      push_csr(REG_RESERVED, 0);
      push_csr(REG_TOTAL, 2047);
      push_request(FUNC_ALLOC, 0, 0);
      push_request(FUNC_QUERY, 0, 0);
      push_request(FUNC_QUERY, 1023, 0);

      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            1: begin r = 0; t = 0; end
            3: begin r = 1024; t = 1024; end
            5: begin r = 2047; t = 1023; end
            7: begin r = 1; t = 2047; end
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  r = $urandom_range(0, 1);
                  t = 1024;
               end else begin
                  r = $urandom_range(0, 990);
                  t = r + $urandom_range(1, 40);
               end
            end
         endcase
         push_csr(REG_RESERVED, r);
         push_csr(REG_TOTAL, t);
         lo = r;
         hi = (t > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : t;
         burst = ($urandom_range(0, 3) == 0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
               func = FUNC_ALLOC;
            end else if (sel < 70) begin
               func = FUNC_FREE;
            end else if (sel < 95) begin
               func = FUNC_QUERY;
            end else begin
               func = FUNC_UNKNOWN;
            end
            sel = $urandom_range(0, 19);
            if (burst || sel < 10) begin
               gap = 0;
            end else if (sel < 18) begin
               gap = $urandom_range(1, 3);
            end else begin
               gap = $urandom_range(8, 40);
            end
            push_request(func, pick_index(lo, hi), gap);
            if ($urandom_range(0, 59) == 0) begin
               push_drain();
            end
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_requests || expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
